// ===== rtl/core/awsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package awsu_pkg;

  // Grid limits
  localparam int unsigned MAX_NX_DEF = 256;
  localparam int unsigned MAX_NY_DEF = 256;
  localparam int unsigned MAX_NZ     = 4096;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 3'd0,
    CFG_SIZE_Y = 3'd1,
    CFG_SIZE_Z = 3'd2,
    CFG_INV_DX = 3'd3,
    CFG_INV_DY = 3'd4,
    CFG_INV_DZ = 3'd5
  } cfg_idx_e;

  // Window read slots: center, then minus/plus per axis
  typedef enum logic [2:0] {
    RD_C  = 3'd0,
    RD_XM = 3'd1,
    RD_XP = 3'd2,
    RD_YM = 3'd3,
    RD_YP = 3'd4,
    RD_ZM = 3'd5,
    RD_ZP = 3'd6
  } rd_sel_e;

  // Multiplier operand pair
  typedef enum logic [1:0] {
    AX_X    = 2'd0,
    AX_Y    = 2'd1,
    AX_Z    = 2'd2,
    AX_COEF = 2'd3
  } axis_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    take;
    logic    write;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    diff;
    logic    mul_en;
    logic    mul_hi;
    axis_e   axis;
    logic    acc_ld;
    logic    acc_add;
    logic    lap_add;
    logic    lap_sat;
    logic    term;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;
    logic wall;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/awsu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awsu_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  awsu_pkg::dp_status_t status_i,
  output awsu_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_PREP   = 13'b0000000000010,
    S_WRITE  = 13'b0000000000100,
    S_READ   = 13'b0000000001000,
    S_DRAIN  = 13'b0000000010000,
    S_DIFF   = 13'b0000000100000,
    S_MUL_LO = 13'b0000001000000,
    S_MUL_HI = 13'b0000010000000,
    S_ACC    = 13'b0000100000000,
    S_LAP    = 13'b0001000000000,
    S_SAT    = 13'b0010000000000,
    S_TERM   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  awsu_pkg::rd_sel_e rd_q, rd_d;
  awsu_pkg::axis_e   ax_q, ax_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    rd_d    = rd_q;
    ax_d    = ax_q;
    cmd_o   = '0;
    cmd_o.rd_sel = rd_q;
    cmd_o.axis   = ax_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: state_d = S_WRITE;
      S_WRITE: begin
        cmd_o.write = 1'b1;
        rd_d = awsu_pkg::RD_C;
        if (!status_i.emit) state_d = S_IDLE;
        else if (status_i.wall) state_d = S_OUT;
        else state_d = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        if (rd_q == awsu_pkg::RD_ZP) state_d = S_DRAIN;
        else rd_d = awsu_pkg::rd_sel_e'(rd_q + 3'd1);
      end
      S_DRAIN: state_d = S_DIFF;
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        ax_d = awsu_pkg::AX_X;
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = 1'b1;
        cmd_o.acc_ld = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d = (ax_q == awsu_pkg::AX_COEF) ? S_TERM : S_LAP;
      end
      S_LAP: begin
        cmd_o.lap_add = 1'b1;
        unique case (ax_q)
          awsu_pkg::AX_X: begin
            ax_d = awsu_pkg::AX_Y;
            state_d = S_MUL_LO;
          end
          awsu_pkg::AX_Y: begin
            ax_d = awsu_pkg::AX_Z;
            state_d = S_MUL_LO;
          end
          default: state_d = S_SAT;
        endcase
      end
      S_SAT: begin
        cmd_o.lap_sat = 1'b1;
        ax_d = awsu_pkg::AX_COEF;
        state_d = S_MUL_LO;
      end
      S_TERM: begin
        cmd_o.term = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_q    <= awsu_pkg::RD_C;
      ax_q    <= awsu_pkg::AX_X;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      ax_q    <= ax_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/awsu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awsu_datapath #(
  parameter int unsigned MAX_NX = awsu_pkg::MAX_NX_DEF,
  parameter int unsigned MAX_NY = awsu_pkg::MAX_NY_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [awsu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [awsu_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire  signed [31:0]                  p_now_i,
  input  wire  signed [31:0]                  p_prev_i,
  input  wire  [31:0]                         coef_i,
  input  wire                                 out_ready_i,
  output logic                                out_valid_o,
  output logic signed [31:0]                  p_next_o,
  output logic                                last_o,
  input  awsu_pkg::dp_cmd_t                   cmd_i,
  output awsu_pkg::dp_status_t                status_o
);

  localparam int unsigned NX_W      = $clog2(MAX_NX + 1);
  localparam int unsigned NY_W      = $clog2(MAX_NY + 1);
  localparam int unsigned NZ_W      = $clog2(awsu_pkg::MAX_NZ + 1);
  localparam int unsigned LAG_MAX   = MAX_NX * MAX_NY;
  localparam int unsigned LAG_W     = $clog2(LAG_MAX + 1);
  localparam int unsigned WIN_DEPTH = 2 * LAG_MAX + 1;
  localparam int unsigned WA_W      = $clog2(WIN_DEPTH);
  localparam int unsigned DLY_DEPTH = LAG_MAX + MAX_NX + 1;
  localparam int unsigned DA_W      = $clog2(DLY_DEPTH);
  localparam longint unsigned TL_MAX =
    longint'(LAG_MAX) * longint'(awsu_pkg::MAX_NZ + 1);
  localparam int unsigned POS_W     = $clog2(TL_MAX + 1);
  localparam int unsigned LAP_W     = 52;
  localparam int unsigned ACC_W     = 81;

  localparam logic signed [LAP_W-1:0] LAP_HI = {{(LAP_W-47){1'b0}}, {47{1'b1}}};
  localparam logic signed [LAP_W-1:0] LAP_LO = {{(LAP_W-47){1'b1}}, {47{1'b0}}};
  localparam logic signed [64:0] TERM_HI = {{24{1'b0}}, 1'b1, {40{1'b0}}};
  localparam logic signed [64:0] TERM_LO = {{25{1'b1}}, {40{1'b0}}};
  localparam logic signed [43:0] RES_HI  = {{13{1'b0}}, {31{1'b1}}};
  localparam logic signed [43:0] RES_LO  = {{13{1'b1}}, {31{1'b0}}};

  // Configuration registers
  logic [8:0]  size_x_q, size_y_q;
  logic [12:0] size_z_q;
  logic [31:0] inv_dx_q, inv_dy_q, inv_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 9'd256;
      size_y_q <= 9'd1;
      size_z_q <= 13'd256;
      inv_dx_q <= 32'd65536;
      inv_dy_q <= 32'd65536;
      inv_dz_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (awsu_pkg::cfg_idx_e'(cfg_idx_i))
        awsu_pkg::CFG_SIZE_X: size_x_q <= cfg_data_i[8:0];
        awsu_pkg::CFG_SIZE_Y: size_y_q <= cfg_data_i[8:0];
        awsu_pkg::CFG_SIZE_Z: size_z_q <= cfg_data_i[12:0];
        awsu_pkg::CFG_INV_DX: inv_dx_q <= cfg_data_i;
        awsu_pkg::CFG_INV_DY: inv_dy_q <= cfg_data_i;
        awsu_pkg::CFG_INV_DZ: inv_dz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp grid sizes
  logic [NX_W-1:0] nx;
  logic [NY_W-1:0] ny;
  logic [NZ_W-1:0] nz;
  logic            flat;

  always_comb begin
    if (size_x_q < 9'd3) nx = NX_W'(3);
    else if (32'(size_x_q) > MAX_NX) nx = NX_W'(MAX_NX);
    else nx = NX_W'(size_x_q);
    if (size_y_q == 9'd0) ny = NY_W'(1);
    else if (32'(size_y_q) > MAX_NY) ny = NY_W'(MAX_NY);
    else ny = NY_W'(size_y_q);
    if (size_z_q < 13'd3) nz = NZ_W'(3);
    else if (32'(size_z_q) > awsu_pkg::MAX_NZ) nz = NZ_W'(awsu_pkg::MAX_NZ);
    else nz = NZ_W'(size_z_q);
  end
  assign flat = (ny == NY_W'(1));

  // Plane size and pass length, two register stages
  logic [NX_W+NY_W-1:0]  lag_full;
  logic [LAG_W-1:0]      lag_q;
  logic [NZ_W:0]         nz1;
  logic [LAG_W+NZ_W-1:0] total_full;
  logic [LAG_W+NZ_W:0]   tl_full;
  logic [POS_W-1:0]      total_q, tl_q;

  assign lag_full   = nx * ny;
  assign nz1        = {1'b0, nz} + 1'b1;
  assign total_full = lag_q * nz;
  assign tl_full    = lag_q * nz1;

  always_ff @(posedge clk_i) begin
    lag_q   <= LAG_W'(lag_full);
    total_q <= POS_W'(total_full);
    tl_q    <= POS_W'(tl_full);
  end

  // Input latch
  logic [31:0] p_now_q, p_prev_q, coef_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      p_now_q  <= p_now_i;
      p_prev_q <= p_prev_i;
      coef_q   <= coef_i;
    end
  end

  // Stream position and grid coordinates of the emitted point
  logic [POS_W-1:0] pos_q, pos_eff, pos_inc;
  logic [NX_W-1:0]  mx_q;
  logic [NY_W-1:0]  my_q;
  logic [NZ_W-1:0]  mz_q;
  logic [WA_W-1:0]  wp_q, wbase_q;
  logic [DA_W-1:0]  dp_q, dbase_q;
  logic             fin, pad, emit, wall;
  logic             wall_q, last_q;
  logic [WA_W:0]    wbase_d;
  logic [DA_W:0]    dbase_d;

  assign pos_eff = (pos_q >= tl_q) ? '0 : pos_q;
  assign pos_inc = pos_eff + 1'b1;
  assign fin     = (pos_inc == tl_q);
  assign pad     = (pos_eff >= total_q);
  assign emit    = (pos_eff >= POS_W'(lag_q));
  assign wall    = (mx_q == '0) || (mx_q == nx - 1'b1) ||
                   (mz_q == '0) || (mz_q == nz - 1'b1) ||
                   (!flat && ((my_q == '0) || (my_q == ny - 1'b1)));

  // Point of the emitted result in each memory
  always_comb begin
    if ({1'b0, wp_q} >= (WA_W+1)'(lag_q)) wbase_d = {1'b0, wp_q} - (WA_W+1)'(lag_q);
    else wbase_d = {1'b0, wp_q} + (WA_W+1)'(WIN_DEPTH) - (WA_W+1)'(lag_q);
    if ({1'b0, dp_q} >= (DA_W+1)'(lag_q)) dbase_d = {1'b0, dp_q} - (DA_W+1)'(lag_q);
    else dbase_d = {1'b0, dp_q} + (DA_W+1)'(DLY_DEPTH) - (DA_W+1)'(lag_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      mx_q  <= '0;
      my_q  <= '0;
      mz_q  <= '0;
      wp_q  <= '0;
      dp_q  <= '0;
    end else if (cmd_i.write) begin
      pos_q <= fin ? '0 : pos_inc;
      wp_q  <= (wp_q == WA_W'(WIN_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      dp_q  <= (dp_q == DA_W'(DLY_DEPTH - 1)) ? '0 : dp_q + 1'b1;
      if (pos_eff == '0) begin
        mx_q <= '0;
        my_q <= '0;
        mz_q <= '0;
      end else if (emit) begin
        if (mx_q == nx - 1'b1) begin
          mx_q <= '0;
          if (my_q == ny - 1'b1) begin
            my_q <= '0;
            mz_q <= mz_q + 1'b1;
          end else begin
            my_q <= my_q + 1'b1;
          end
        end else begin
          mx_q <= mx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      wbase_q <= wbase_d[WA_W-1:0];
      dbase_q <= dbase_d[DA_W-1:0];
      wall_q  <= wall;
      last_q  <= fin;
    end
  end

  // Pressure window and delay lines
  logic [31:0] win_mem  [WIN_DEPTH];
  logic [31:0] prev_mem [DLY_DEPTH];
  logic [31:0] coef_mem [DLY_DEPTH];
  logic [31:0] win_rd_q, prev_rd_q, coef_rd_q;
  logic [LAG_W-1:0] off;
  logic             minus;
  logic [WA_W:0]    sum_p, raddr_w;
  logic [WA_W-1:0]  raddr;

  always_comb begin
    off   = '0;
    minus = 1'b0;
    case (cmd_i.rd_sel)
      awsu_pkg::RD_XM: begin off = LAG_W'(1); minus = 1'b1; end
      awsu_pkg::RD_XP: off = LAG_W'(1);
      awsu_pkg::RD_YM: begin off = LAG_W'(nx); minus = 1'b1; end
      awsu_pkg::RD_YP: off = LAG_W'(nx);
      awsu_pkg::RD_ZM: begin off = lag_q; minus = 1'b1; end
      awsu_pkg::RD_ZP: off = lag_q;
      default: ;
    endcase
    sum_p = {1'b0, wbase_q} + (WA_W+1)'(off);
    if (minus) begin
      if ({1'b0, wbase_q} >= (WA_W+1)'(off)) raddr_w = {1'b0, wbase_q} - (WA_W+1)'(off);
      else raddr_w = {1'b0, wbase_q} + (WA_W+1)'(WIN_DEPTH) - (WA_W+1)'(off);
    end else begin
      raddr_w = (sum_p >= (WA_W+1)'(WIN_DEPTH)) ? sum_p - (WA_W+1)'(WIN_DEPTH) : sum_p;
    end
    raddr = raddr_w[WA_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      win_mem[wp_q]  <= pad ? 32'd0 : p_now_q;
      prev_mem[dp_q] <= p_prev_q;
      coef_mem[dp_q] <= coef_q;
    end
    if (cmd_i.rd_en) win_rd_q <= win_mem[raddr];
    if (cmd_i.rd_en && (cmd_i.rd_sel == awsu_pkg::RD_C)) begin
      prev_rd_q <= prev_mem[dbase_q];
      coef_rd_q <= coef_mem[dbase_q];
    end
  end

  // Capture neighbors in the cycle after read data lands
  logic              cap_q;
  awsu_pkg::rd_sel_e cap_sel_q;
  logic [31:0]       nb_q [7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= 1'b0;
      cap_sel_q <= awsu_pkg::RD_C;
    end else begin
      cap_q     <= cmd_i.rd_en;
      cap_sel_q <= cmd_i.rd_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_q) nb_q[cap_sel_q] <= win_rd_q;
  end

  // Second differences per axis
  logic [31:0]        pc, xm, xp, ym, yp, zm, zp;
  logic signed [32:0] c2_q;
  logic signed [33:0] dx_q, dy_q, dz_q;
  logic [33:0]        c2e;

  assign pc  = nb_q[awsu_pkg::RD_C];
  assign xm  = nb_q[awsu_pkg::RD_XM];
  assign xp  = nb_q[awsu_pkg::RD_XP];
  assign ym  = nb_q[awsu_pkg::RD_YM];
  assign yp  = nb_q[awsu_pkg::RD_YP];
  assign zm  = nb_q[awsu_pkg::RD_ZM];
  assign zp  = nb_q[awsu_pkg::RD_ZP];
  assign c2e = {pc[31], pc, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      c2_q <= {pc, 1'b0};
      dx_q <= {{2{xm[31]}}, xm} + {{2{xp[31]}}, xp} - c2e;
      dy_q <= flat ? '0 : {{2{ym[31]}}, ym} + {{2{yp[31]}}, yp} - c2e;
      dz_q <= {{2{zm[31]}}, zm} + {{2{zp[31]}}, zp} - c2e;
    end
  end

  // Shared multiplier: 48-bit signed by 16-bit half of the unsigned factor
  logic signed [47:0]      mul_a;
  logic [31:0]             mul_full_b;
  logic signed [16:0]      mul_b;
  logic signed [64:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [64:0]      acc_fl;
  logic signed [LAP_W-1:0] lap_q;
  logic signed [41:0]      term_q;

  always_comb begin
    case (cmd_i.axis)
      awsu_pkg::AX_X: begin
        mul_a = {{14{dx_q[33]}}, dx_q};
        mul_full_b = inv_dx_q;
      end
      awsu_pkg::AX_Y: begin
        mul_a = {{14{dy_q[33]}}, dy_q};
        mul_full_b = inv_dy_q;
      end
      awsu_pkg::AX_Z: begin
        mul_a = {{14{dz_q[33]}}, dz_q};
        mul_full_b = inv_dz_q;
      end
      default: begin
        mul_a = lap_q[47:0];
        mul_full_b = coef_rd_q;
      end
    endcase
    mul_b = {1'b0, (cmd_i.mul_hi ? mul_full_b[31:16] : mul_full_b[15:0])};
  end

  assign acc_fl = acc_q[ACC_W-1:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.acc_ld) acc_q <= {{16{prod_q[64]}}, prod_q};
    else if (cmd_i.acc_add) acc_q <= acc_q + {prod_q, 16'b0};
    if (cmd_i.diff) lap_q <= '0;
    else if (cmd_i.lap_add) lap_q <= lap_q + acc_fl[LAP_W-1:0];
    else if (cmd_i.lap_sat) begin
      if (lap_q > LAP_HI) lap_q <= LAP_HI;
      else if (lap_q < LAP_LO) lap_q <= LAP_LO;
    end
    if (cmd_i.term) begin
      if (acc_fl > TERM_HI) term_q <= TERM_HI[41:0];
      else if (acc_fl < TERM_LO) term_q <= TERM_LO[41:0];
      else term_q <= acc_fl[41:0];
    end
  end

  // Final sum and output register
  logic signed [43:0] res;
  logic signed [31:0] res_sat;

  assign res = {{11{c2_q[32]}}, c2_q} - {{12{prev_rd_q[31]}}, prev_rd_q} +
               {{2{term_q[41]}}, term_q};

  always_comb begin
    if (res > RES_HI) res_sat = RES_HI[31:0];
    else if (res < RES_LO) res_sat = RES_LO[31:0];
    else res_sat = res[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      p_next_o <= wall_q ? 32'sd0 : res_sat;
      last_o   <= last_q;
    end
  end

  assign status_o.emit     = emit;
  assign status_o.wall     = wall;
  assign status_o.out_free = !out_valid_o || out_ready_i;

endmodule

`default_nettype wire

// ===== rtl/core/acoustic_wave_stencil_update.sv =====
// Interior point: write, seven window reads, differences, axis products, saturation, coefficient
// product, then the result. Wall point: the write, then the result. Lead-in request: no result.
// Rate is set by the single window memory read port (seven reads per point) and the shared
// multiplier (eight half-width products per point). A full output register stalls only the end.
// Reset: registers return to their default sizes and spacings, stream position goes to zero;
// window and delay memories are not cleared and hold data only once written.
`timescale 1ns / 1ps
`default_nettype none

module acoustic_wave_stencil_update #(
  parameter int unsigned MAX_NX = awsu_pkg::MAX_NX_DEF,
  parameter int unsigned MAX_NY = awsu_pkg::MAX_NY_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [awsu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [awsu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  signed [31:0]               p_now_i,
  input  wire  signed [31:0]               p_prev_i,
  input  wire  [31:0]                      coef_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic signed [31:0]               p_next_o,
  output logic                             last_o
);

  awsu_pkg::dp_cmd_t    cmd;
  awsu_pkg::dp_status_t status;

  // Sequence one request at a time
  awsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Buffers, stencil arithmetic and output register
  awsu_datapath #(
    .MAX_NX (MAX_NX),
    .MAX_NY (MAX_NY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .p_now_i     (p_now_i),
    .p_prev_i    (p_prev_i),
    .coef_i      (coef_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .p_next_o    (p_next_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

// ===== tb/tb_acoustic_wave_stencil_update.sv =====
`timescale 1ns / 1ps

// Tracks grid geometry and spacing registers, recomputes each stencil update
// from the requests seen so far, and matches results in order.
class stencil_scoreboard;
  bit [8:0]  reg_sx;
  bit [8:0]  reg_sy;
  bit [12:0] reg_sz;
  bit [31:0] inv_x, inv_y, inv_z;
  longint    pos;
  bit [31:0] pres_win[longint];
  bit [31:0] prev_dly[longint];
  bit [31:0] coef_dly[longint];
  bit [31:0] exp_p_next[$];
  bit        exp_last[$];
  int        errors;
  int        matched;
  int        requests;

  function new();
    reg_sx = 9'd256; reg_sy = 9'd1; reg_sz = 13'd256;
    inv_x = 32'd65536; inv_y = 32'd65536; inv_z = 32'd65536;
    pos = 0; errors = 0; matched = 0; requests = 0;
  endfunction

  function void set_reg(awsu_pkg::cfg_idx_e idx, bit [31:0] v);
    case (idx)
      awsu_pkg::CFG_SIZE_X: reg_sx = v[8:0];
      awsu_pkg::CFG_SIZE_Y: reg_sy = v[8:0];
      awsu_pkg::CFG_SIZE_Z: reg_sz = v[12:0];
      awsu_pkg::CFG_INV_DX: inv_x = v;
      awsu_pkg::CFG_INV_DY: inv_y = v;
      awsu_pkg::CFG_INV_DZ: inv_z = v;
      default: ;
    endcase
  endfunction

  function longint clampi(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function longint grid_x();
    return clampi(longint'(reg_sx), 3, 256);
  endfunction

  function longint grid_y();
    return clampi(longint'(reg_sy), 1, 256);
  endfunction

  function longint grid_z();
    return clampi(longint'(reg_sz), 3, 4096);
  endfunction

  // Requests in one full pass: grid points plus one plane of flush padding
  function longint pass_len();
    return grid_x() * grid_y() * (grid_z() + 1);
  endfunction

  function longint win_at(longint idx);
    return longint'($signed(pres_win[idx]));
  endfunction

  // floor(a * b / 2^16), split into halves to stay within 64 bits
  function longint mul_q16(longint a, bit [31:0] b);
    longint hi_part, lo_part;
    hi_part = a * longint'({48'd0, b[31:16]});
    lo_part = (a * longint'({48'd0, b[15:0]})) >>> 16;
    return hi_part + lo_part;
  endfunction

  function void note_request(bit [31:0] p_now, bit [31:0] p_prev, bit [31:0] coef);
    longint nx, ny, nz, lag, total, m, x, y, z, p, c2, lap, term, res;
    bit flat, wall, fin;
    nx = grid_x(); ny = grid_y(); nz = grid_z();
    flat = (ny == 1);
    lag = nx * ny;
    total = lag * nz;
    requests++;
    if (pos >= total + lag) pos = 0;
    if (pos == 0) begin
      pres_win.delete(); prev_dly.delete(); coef_dly.delete();
    end
    pres_win[pos] = (pos < total) ? p_now : 32'd0;
    prev_dly[pos] = p_prev;
    coef_dly[pos] = coef;
    // Hold back results until one plane has streamed in
    if (pos < lag) begin
      pos++;
      return;
    end
    m = pos - lag;
    x = m % nx;
    y = (m / nx) % ny;
    z = (m / nx) / ny;
    wall = (x == 0) || (x == nx - 1) || (z == 0) || (z == nz - 1) ||
           (!flat && ((y == 0) || (y == ny - 1)));
    res = 0;
    if (!wall) begin
      p = win_at(m);
      c2 = 2 * p;
      lap = mul_q16(win_at(m - 1) + win_at(m + 1) - c2, inv_x);
      if (!flat) lap += mul_q16(win_at(m - nx) + win_at(m + nx) - c2, inv_y);
      lap += mul_q16(win_at(m - lag) + win_at(m + lag) - c2, inv_z);
      lap = clampi(lap, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
      term = clampi(mul_q16(lap, coef_dly[m]), -(64'sd1 <<< 40), 64'sd1 <<< 40);
      res = c2 - longint'($signed(prev_dly[m])) + term;
      res = clampi(res, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    end
    fin = (m == total - 1);
    exp_p_next.push_back(res[31:0]);
    exp_last.push_back(fin);
    pos = fin ? 0 : pos + 1;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_result(bit [31:0] p_next, bit last);
    bit [31:0] want_p;
    bit        want_last;
    if (exp_p_next.size() == 0) begin
      flag($sformatf("unexpected result p_next=%08h last=%0b", p_next, last));
      return;
    end
    want_p = exp_p_next.pop_front();
    want_last = exp_last.pop_front();
    matched++;
    if (p_next !== want_p)
      flag($sformatf("result %0d p_next expected %08h actual %08h",
                     matched, want_p, p_next));
    if (last !== want_last)
      flag($sformatf("result %0d last expected %0b actual %0b",
                     matched, want_last, last));
  endfunction

  function int pending();
    return exp_p_next.size();
  endfunction
endclass

module tb_acoustic_wave_stencil_update;

  localparam longint CYCLE_LIMIT = 6000000;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [awsu_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [awsu_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic signed [31:0]              p_now_i;
  logic signed [31:0]              p_prev_i;
  logic [31:0]                     coef_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic signed [31:0]              p_next_o;
  logic                            last_o;

  stencil_scoreboard sb;
  longint cycles;
  bit     quiet;
  bit     hold_req;
  int     hold_left;
  int     stall_left;
  int     passes;

  acoustic_wave_stencil_update u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .p_now_i    (p_now_i),
    .p_prev_i   (p_prev_i),
    .coef_i     (coef_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .p_next_o   (p_next_o),
    .last_o     (last_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL acoustic_wave_stencil_update");
      $finish;
    end
  end

  // Drive result ready: long hold on request, always ready when quiet, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: stall_left <= $urandom_range(0, 3);
        4:          stall_left <= $urandom_range(10, 40);
        default:    stall_left <= 0;
      endcase
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(p_next_o, last_o);
  end

  function automatic bit [31:0] rand_pressure();
    bit [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      1, 2: v = $urandom();
      default: begin
        v = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic bit [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2, 3: return $urandom();
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic bit [31:0] rand_spacing();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom();
      default: return $urandom_range(1 << 14, 1 << 18);
    endcase
  endfunction

  task automatic cfg_write(awsu_pkg::cfg_idx_e idx, bit [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Lower valid and wait until all results are in and the block has settled
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_request(bit [31:0] pn, bit [31:0] pp, bit [31:0] cf);
    int gap;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 19))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    p_now_i <= pn;
    p_prev_i <= pp;
    coef_i <= cf;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_request(pn, pp, cf);
  endtask

  task automatic run_pass(bit [8:0] sx, bit [8:0] sy, bit [12:0] sz,
                          bit [31:0] ix, bit [31:0] iy, bit [31:0] iz);
    longint n;
    drain();
    cfg_write(awsu_pkg::CFG_SIZE_X, 32'(sx));
    cfg_write(awsu_pkg::CFG_SIZE_Y, 32'(sy));
    cfg_write(awsu_pkg::CFG_SIZE_Z, 32'(sz));
    cfg_write(awsu_pkg::CFG_INV_DX, ix);
    cfg_write(awsu_pkg::CFG_INV_DY, iy);
    cfg_write(awsu_pkg::CFG_INV_DZ, iz);
    n = sb.pass_len();
    for (longint i = 0; i < n; i++)
      send_request(rand_pressure(), rand_pressure(), rand_coef());
    passes++;
  endtask

  initial begin
    longint random_start;
    sb = new();
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    passes = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = awsu_pkg::CFG_SIZE_X;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    p_now_i = '0;
    p_prev_i = '0;
    coef_i = '0;
    out_ready_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest grid, clamped-low sizes, two y planes, extreme spacings
    run_pass(9'd3, 9'd1, 13'd3, 32'd65536, 32'd65536, 32'd65536);
    run_pass(9'd0, 9'd0, 13'd0, 32'hffff_ffff, 32'd0, 32'hffff_ffff);
    run_pass(9'd4, 9'd2, 13'd3, 32'd65536, 32'd65536, 32'd65536);
    run_pass(9'd4, 9'd3, 13'd4, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    run_pass(9'd5, 9'd4, 13'd4, 32'd0, 32'd0, 32'd0);

    // Random passes on small grids; hold results off early to back up the input
    random_start = sb.requests;
    while (sb.requests - random_start < 680) begin
      if (passes == 9) hold_req = 1'b1;
      quiet = ($urandom_range(0, 5) == 0);
      run_pass(9'($urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 6)),
               9'($urandom_range(0, 4)),
               13'($urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 5)),
               rand_spacing(), rand_spacing(), rand_spacing());
    end
    quiet = 1'b0;
    drain();

    $display("covered %0d passes, %0d requests, %0d results checked",
             passes, sb.requests, sb.matched);
    $display("small grids with clamped-low sizes, 2D and 3D, saturating spacings");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS acoustic_wave_stencil_update");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("FAIL acoustic_wave_stencil_update");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/awsu_pkg.sv
rtl/core/awsu_ctrl.sv
rtl/core/awsu_datapath.sv
rtl/core/acoustic_wave_stencil_update.sv
tb/tb_acoustic_wave_stencil_update.sv
